/* rtl/core/nearest_equivalent_orientation_defines.svh */
// Assertion macros for the nearest equivalent orientation block.
`ifndef NEAREST_EQUIVALENT_ORIENTATION_DEFINES_SVH
`define NEAREST_EQUIVALENT_ORIENTATION_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define NEO_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("neo: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define NEO_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("neo: next-cycle check failed");

`else

`define NEO_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define NEO_ASSERT_NXT(lbl, clk, rst_n, a, b)

`endif

`endif

/* rtl/core/neo_pkg.sv */
package neo_pkg;

    // Angle widths: Q4.27 inputs, reduced angles stay inside (-2^30, 2^30)
    localparam int ANG_W = 32;
    localparam int RED_W = 31;

    // 2*pi in Q4.27, rounded to nearest
    localparam logic signed [RED_W-1:0] TWO_PI_Q27 = 31'sd843314857;

    // Load enables for the two reduction stages
    typedef struct packed {
        logic s1;
        logic s2;
    } reduce_en_t;

endpackage

/* rtl/core/neo_if.sv */
interface neo_cmd_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       cur_rx;
    logic signed [31:0]       cur_ry;
    logic signed [31:0]       cur_rz;
    logic signed [31:0]       tgt_rx;
    logic signed [31:0]       tgt_ry;
    logic signed [31:0]       tgt_rz;
    logic        [3:0]        group_id;
    logic        [3:0]        axis_count;

    modport source (
        output valid, cur_rx, cur_ry, cur_rz, tgt_rx, tgt_ry, tgt_rz,
               group_id, axis_count,
        input  ready
    );
    modport sink (
        input  valid, cur_rx, cur_ry, cur_rz, tgt_rx, tgt_ry, tgt_rz,
               group_id, axis_count,
        output ready
    );
endinterface

interface neo_rsp_if;
    logic                     valid;
    logic                     ready;
    logic signed [32:0]       offset_rx;
    logic signed [32:0]       offset_ry;
    logic signed [32:0]       offset_rz;
    logic                     applied;

    modport source (
        output valid, offset_rx, offset_ry, offset_rz, applied,
        input  ready
    );
    modport sink (
        input  valid, offset_rx, offset_ry, offset_rz, applied,
        output ready
    );
endinterface

/* rtl/core/neo_reduce.sv */
// Two-stage truncating reduction of one angle modulo 2*pi.
module neo_reduce (
    input  logic                                  clk,
    input  neo_pkg::reduce_en_t                   en,
    input  logic signed [neo_pkg::ANG_W-1:0]      ang,
    output logic signed [neo_pkg::RED_W-1:0]      red
);

    localparam logic signed [neo_pkg::ANG_W-1:0] TWO_PI_W =
        neo_pkg::ANG_W'(neo_pkg::TWO_PI_Q27);

    logic signed [neo_pkg::ANG_W-1:0] step1_reg;
    logic signed [neo_pkg::ANG_W-1:0] step1_next;
    logic signed [neo_pkg::ANG_W-1:0] step2_full;
    logic signed [neo_pkg::RED_W-1:0] red_reg;

    // One step: pull the value toward zero by 2*pi, keeping its sign
    function automatic logic signed [neo_pkg::ANG_W-1:0] wrap_step(
        input logic signed [neo_pkg::ANG_W-1:0] x
    );
        logic signed [neo_pkg::ANG_W-1:0] r;
        begin
            r = x;
            if (!x[neo_pkg::ANG_W-1] && (x >= TWO_PI_W))
            begin
                r = x - TWO_PI_W;
            end
            else if (x[neo_pkg::ANG_W-1] && (x <= -TWO_PI_W))
            begin
                r = x + TWO_PI_W;
            end
            return r;
        end
    endfunction

    assign step1_next = wrap_step(ang);
    assign step2_full = wrap_step(step1_reg);

    // First step
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            step1_reg <= step1_next;
        end
    end

    // Second step; the result now fits the narrow width
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            red_reg <= step2_full[neo_pkg::RED_W-1:0];
        end
    end

    assign red = red_reg;

endmodule

/* rtl/core/nearest_equivalent_orientation.sv */
// Channel  | Modport | Transaction
// ---------+---------+----------------------------------------------------------
// cmd      | sink    | current and target rx/ry/rz, group_id, axis_count
// rsp      | source  | offset_rx/ry/rz (Q5.27), applied
//
// Ten register stages; one transaction enters per cycle while rsp is not stalled,
// and its result leaves from the last stage. Stages in order: modulo reduction (2),
// flip (1), difference (1), magnitude (1), 32x32 squares (1), two sum adds (2),
// two compare levels (2).
// Reset clears only the stage valid bits. Each stage loads whenever it is
// empty or the stage after it loads, so bubbles collapse under a stall.
`include "nearest_equivalent_orientation_defines.svh"

module nearest_equivalent_orientation (
    input  logic       clk,
    input  logic       rst_n,
    neo_cmd_if.sink    cmd,
    neo_rsp_if.source  rsp
);

    localparam int NUM_STAGES = 10;
    localparam logic [3:0] AXES_REQUIRED = 4'd6;
    localparam logic [3:0] GROUP_PROCESSED = 4'd0;

    // Candidate codes
    localparam logic [1:0] CAND_KEEP    = 2'd0;
    localparam logic [1:0] CAND_FLIP_X  = 2'd1;
    localparam logic [1:0] CAND_FLIP_Z  = 2'd2;
    localparam logic [1:0] CAND_FLIP_XZ = 2'd3;

    localparam int AW = neo_pkg::ANG_W;
    localparam int RW = neo_pkg::RED_W;
    localparam int DW = AW + 1;
    localparam int MW = AW;
    localparam int SW = 2 * MW;

    // Pipeline control
    logic [NUM_STAGES:1]   valid_reg;
    logic [NUM_STAGES:1]   valid_next;
    logic [NUM_STAGES+1:1] stage_en;

    always_comb
    begin
        stage_en[NUM_STAGES+1] = rsp.ready;
        for (int k = NUM_STAGES; k >= 1; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign cmd.ready  = stage_en[1];
    assign valid_next = {valid_reg[NUM_STAGES-1:1], cmd.valid};

    // Advance valid bits stage by stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= (valid_next & stage_en[NUM_STAGES:1])
                       | (valid_reg & ~stage_en[NUM_STAGES:1]);
        end
    end

    // Process flag travels through all stages
    logic ok_reg [1:NUM_STAGES];
    logic ok_next;

    assign ok_next = (cmd.group_id == GROUP_PROCESSED) && (cmd.axis_count == AXES_REQUIRED);

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            ok_reg[1] <= ok_next;
        end
        for (int k = 2; k <= NUM_STAGES; k++)
        begin
            if (stage_en[k])
            begin
                ok_reg[k] <= ok_reg[k-1];
            end
        end
    end

    // Current and target angles, stages 1 to 3
    logic signed [AW-1:0] cur_x_reg [1:3];
    logic signed [AW-1:0] cur_y_reg [1:3];
    logic signed [AW-1:0] cur_z_reg [1:3];
    logic signed [AW-1:0] tgt_x_reg [1:3];
    logic signed [AW-1:0] tgt_y_reg [1:3];
    logic signed [AW-1:0] tgt_z_reg [1:3];

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            cur_x_reg[1] <= cmd.cur_rx;
            cur_y_reg[1] <= cmd.cur_ry;
            cur_z_reg[1] <= cmd.cur_rz;
            tgt_x_reg[1] <= cmd.tgt_rx;
            tgt_y_reg[1] <= cmd.tgt_ry;
            tgt_z_reg[1] <= cmd.tgt_rz;
        end
        for (int k = 2; k <= 3; k++)
        begin
            if (stage_en[k])
            begin
                cur_x_reg[k] <= cur_x_reg[k-1];
                cur_y_reg[k] <= cur_y_reg[k-1];
                cur_z_reg[k] <= cur_z_reg[k-1];
                tgt_x_reg[k] <= tgt_x_reg[k-1];
                tgt_y_reg[k] <= tgt_y_reg[k-1];
                tgt_z_reg[k] <= tgt_z_reg[k-1];
            end
        end
    end

    // Stages 1-2: reduce each current angle modulo 2*pi
    neo_pkg::reduce_en_t  red_en;
    logic signed [RW-1:0] red_x;
    logic signed [RW-1:0] red_y;
    logic signed [RW-1:0] red_z;

    assign red_en.s1 = stage_en[1];
    assign red_en.s2 = stage_en[2];

    neo_reduce u_red_x (.clk(clk), .en(red_en), .ang(cmd.cur_rx), .red(red_x));
    neo_reduce u_red_y (.clk(clk), .en(red_en), .ang(cmd.cur_ry), .red(red_y));
    neo_reduce u_red_z (.clk(clk), .en(red_en), .ang(cmd.cur_rz), .red(red_z));

    // Stage 3: shift x and z by 2*pi toward the other sign
    logic signed [RW-1:0] red_x_reg;
    logic signed [RW-1:0] red_y_reg;
    logic signed [RW-1:0] red_z_reg;
    logic signed [RW-1:0] flip_x_reg;
    logic signed [RW-1:0] flip_z_reg;
    logic signed [RW-1:0] flip_x_next;
    logic signed [RW-1:0] flip_z_next;

    assign flip_x_next = red_x[RW-1] ? (red_x + neo_pkg::TWO_PI_Q27)
                                     : (red_x - neo_pkg::TWO_PI_Q27);
    assign flip_z_next = red_z[RW-1] ? (red_z + neo_pkg::TWO_PI_Q27)
                                     : (red_z - neo_pkg::TWO_PI_Q27);

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            red_x_reg  <= red_x;
            red_y_reg  <= red_y;
            red_z_reg  <= red_z;
            flip_x_reg <= flip_x_next;
            flip_z_reg <= flip_z_next;
        end
    end

    // Stage 4: distances to target and offsets from current
    logic signed [DW-1:0] dx0_reg, dxr_reg, dxf_reg, dy0_reg, dyr_reg;
    logic signed [DW-1:0] dz0_reg, dzr_reg, dzf_reg;
    logic signed [DW-1:0] oxr_reg [4:9];
    logic signed [DW-1:0] oxf_reg [4:9];
    logic signed [DW-1:0] oyr_reg [4:9];
    logic signed [DW-1:0] ozr_reg [4:9];
    logic signed [DW-1:0] ozf_reg [4:9];

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            dx0_reg    <= DW'(tgt_x_reg[3]) - DW'(cur_x_reg[3]);
            dxr_reg    <= DW'(tgt_x_reg[3]) - DW'(red_x_reg);
            dxf_reg    <= DW'(tgt_x_reg[3]) - DW'(flip_x_reg);
            dy0_reg    <= DW'(tgt_y_reg[3]) - DW'(cur_y_reg[3]);
            dyr_reg    <= DW'(tgt_y_reg[3]) - DW'(red_y_reg);
            dz0_reg    <= DW'(tgt_z_reg[3]) - DW'(cur_z_reg[3]);
            dzr_reg    <= DW'(tgt_z_reg[3]) - DW'(red_z_reg);
            dzf_reg    <= DW'(tgt_z_reg[3]) - DW'(flip_z_reg);
            oxr_reg[4] <= DW'(red_x_reg)  - DW'(cur_x_reg[3]);
            oxf_reg[4] <= DW'(flip_x_reg) - DW'(cur_x_reg[3]);
            oyr_reg[4] <= DW'(red_y_reg)  - DW'(cur_y_reg[3]);
            ozr_reg[4] <= DW'(red_z_reg)  - DW'(cur_z_reg[3]);
            ozf_reg[4] <= DW'(flip_z_reg) - DW'(cur_z_reg[3]);
        end
        for (int k = 5; k <= 9; k++)
        begin
            if (stage_en[k])
            begin
                oxr_reg[k] <= oxr_reg[k-1];
                oxf_reg[k] <= oxf_reg[k-1];
                oyr_reg[k] <= oyr_reg[k-1];
                ozr_reg[k] <= ozr_reg[k-1];
                ozf_reg[k] <= ozf_reg[k-1];
            end
        end
    end

    // Stage 5: magnitudes; every difference is below 2^32 in size
    function automatic logic [MW-1:0] mag(input logic signed [DW-1:0] d);
        logic signed [DW-1:0] a;
        begin
            a = d[DW-1] ? -d : d;
            return a[MW-1:0];
        end
    endfunction

    logic [MW-1:0] mx0_reg, mxr_reg, mxf_reg, my0_reg, myr_reg;
    logic [MW-1:0] mz0_reg, mzr_reg, mzf_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            mx0_reg <= mag(dx0_reg);
            mxr_reg <= mag(dxr_reg);
            mxf_reg <= mag(dxf_reg);
            my0_reg <= mag(dy0_reg);
            myr_reg <= mag(dyr_reg);
            mz0_reg <= mag(dz0_reg);
            mzr_reg <= mag(dzr_reg);
            mzf_reg <= mag(dzf_reg);
        end
    end

    // Stage 6: squares, one 32x32 multiplier each
    logic [SW-1:0] qx0_reg, qxr_reg, qxf_reg, qy0_reg, qyr_reg;
    logic [SW-1:0] qz0_reg [6:7];
    logic [SW-1:0] qzr_reg [6:7];
    logic [SW-1:0] qzf_reg [6:7];

    always_ff @(posedge clk)
    begin
        if (stage_en[6])
        begin
            qx0_reg    <= SW'(mx0_reg) * SW'(mx0_reg);
            qxr_reg    <= SW'(mxr_reg) * SW'(mxr_reg);
            qxf_reg    <= SW'(mxf_reg) * SW'(mxf_reg);
            qy0_reg    <= SW'(my0_reg) * SW'(my0_reg);
            qyr_reg    <= SW'(myr_reg) * SW'(myr_reg);
            qz0_reg[6] <= SW'(mz0_reg) * SW'(mz0_reg);
            qzr_reg[6] <= SW'(mzr_reg) * SW'(mzr_reg);
            qzf_reg[6] <= SW'(mzf_reg) * SW'(mzf_reg);
        end
        if (stage_en[7])
        begin
            qz0_reg[7] <= qz0_reg[6];
            qzr_reg[7] <= qzr_reg[6];
            qzf_reg[7] <= qzf_reg[6];
        end
    end

    // Stage 7: x plus y partial sums
    logic [SW:0] pk_reg, pr_reg, pf_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[7])
        begin
            pk_reg <= (SW+1)'(qx0_reg) + (SW+1)'(qy0_reg);
            pr_reg <= (SW+1)'(qxr_reg) + (SW+1)'(qyr_reg);
            pf_reg <= (SW+1)'(qxf_reg) + (SW+1)'(qyr_reg);
        end
    end

    // Stage 8: full squared distances of the four candidates
    logic [SW+1:0] dist_keep_reg, dist_fx_reg, dist_fz_reg, dist_fxz_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[8])
        begin
            dist_keep_reg <= (SW+2)'(pk_reg) + (SW+2)'(qz0_reg[7]);
            dist_fx_reg   <= (SW+2)'(pf_reg) + (SW+2)'(qzr_reg[7]);
            dist_fz_reg   <= (SW+2)'(pr_reg) + (SW+2)'(qzf_reg[7]);
            dist_fxz_reg  <= (SW+2)'(pf_reg) + (SW+2)'(qzf_reg[7]);
        end
    end

    // Stage 9: pairwise minimum, earlier candidate wins ties
    logic [SW+1:0] dist_a_reg, dist_b_reg;
    logic [1:0]    sel_a_reg, sel_b_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[9])
        begin
            if (dist_fx_reg < dist_keep_reg)
            begin
                dist_a_reg <= dist_fx_reg;
                sel_a_reg  <= CAND_FLIP_X;
            end
            else
            begin
                dist_a_reg <= dist_keep_reg;
                sel_a_reg  <= CAND_KEEP;
            end
            if (dist_fxz_reg < dist_fz_reg)
            begin
                dist_b_reg <= dist_fxz_reg;
                sel_b_reg  <= CAND_FLIP_XZ;
            end
            else
            begin
                dist_b_reg <= dist_fz_reg;
                sel_b_reg  <= CAND_FLIP_Z;
            end
        end
    end

    // Stage 10: final pick and offset select
    logic [1:0]           sel;
    logic signed [DW-1:0] off_x_next, off_y_next, off_z_next;
    logic signed [DW-1:0] offset_rx_reg, offset_ry_reg, offset_rz_reg;
    logic                 applied_reg;

    assign sel = (dist_b_reg < dist_a_reg) ? sel_b_reg : sel_a_reg;

    always_comb
    begin
        off_x_next = '0;
        off_y_next = '0;
        off_z_next = '0;
        case (sel)
            CAND_FLIP_X:
            begin
                off_x_next = oxf_reg[9];
                off_y_next = oyr_reg[9];
                off_z_next = ozr_reg[9];
            end
            CAND_FLIP_Z:
            begin
                off_x_next = oxr_reg[9];
                off_y_next = oyr_reg[9];
                off_z_next = ozf_reg[9];
            end
            CAND_FLIP_XZ:
            begin
                off_x_next = oxf_reg[9];
                off_y_next = oyr_reg[9];
                off_z_next = ozf_reg[9];
            end
            default:
            begin
                off_x_next = '0;
                off_y_next = '0;
                off_z_next = '0;
            end
        endcase
        // Drop offsets for commands that are not processed
        if (!ok_reg[9])
        begin
            off_x_next = '0;
            off_y_next = '0;
            off_z_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[10])
        begin
            offset_rx_reg <= off_x_next;
            offset_ry_reg <= off_y_next;
            offset_rz_reg <= off_z_next;
        end
    end

    assign applied_reg   = ok_reg[NUM_STAGES];
    assign rsp.valid     = valid_reg[NUM_STAGES];
    assign rsp.offset_rx = offset_rx_reg;
    assign rsp.offset_ry = offset_ry_reg;
    assign rsp.offset_rz = offset_rz_reg;
    assign rsp.applied   = applied_reg;

    // Checks
    `NEO_ASSERT_IMP(a_skip_zero, clk, rst_n, rsp.valid && !rsp.applied, (rsp.offset_rx == '0) && (rsp.offset_ry == '0) && (rsp.offset_rz == '0))
    `NEO_ASSERT_NXT(a_stage_move, clk, rst_n, valid_reg[4] && stage_en[5], valid_reg[5])
    `NEO_ASSERT_IMP(a_stall_full, clk, rst_n, !stage_en[1], valid_reg == '1)

endmodule

/* dv/nearest_equivalent_orientation_tb.sv */
`timescale 1ns / 1ps

module nearest_equivalent_orientation_tb;

    localparam logic [3:0]         AXES_REQUIRED = 4'd6;
    localparam logic [3:0]         ACTIVE_GROUP  = 4'd0;
    localparam int                 TWO_PI_I      = neo_pkg::TWO_PI_Q27;
    localparam int                 PI_I          = TWO_PI_I / 2;
    localparam logic signed [31:0] ANG_MAX       = 32'sh7fffffff;
    localparam logic signed [31:0] ANG_MIN       = 32'sh80000000;
    localparam int                 RANDOM_CMDS   = 450;

    typedef struct {
        logic signed [31:0] cur_rx;
        logic signed [31:0] cur_ry;
        logic signed [31:0] cur_rz;
        logic signed [31:0] tgt_rx;
        logic signed [31:0] tgt_ry;
        logic signed [31:0] tgt_rz;
        logic        [3:0]  group_id;
        logic        [3:0]  axis_count;
        int                 gap;
    } orient_cmd_t;

    typedef struct {
        logic signed [32:0] offset_rx;
        logic signed [32:0] offset_ry;
        logic signed [32:0] offset_rz;
        logic               applied;
    } orient_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    neo_cmd_if cmd_if ();
    neo_rsp_if rsp_if ();

    orient_cmd_t pending_cmds[$];
    orient_rsp_t expected_offsets[$];
    orient_cmd_t cmd_now;
    orient_rsp_t want;
    int          cmd_hold;
    int          rsp_hold;
    int          results_seen;
    int          mismatch_count = 0;

    nearest_equivalent_orientation dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Truncating modulo 2*pi: the sign follows the dividend, two steps at most
    function automatic longint wrap_two_pi(input longint x);
        longint v;
        v = x;
        for (int k = 0; k < 2; k++)
        begin
            if (v >= 0 && v >= TWO_PI_I)
                v = v - TWO_PI_I;
            else if (v < 0 && v <= -TWO_PI_I)
                v = v + TWO_PI_I;
        end
        return v;
    endfunction

    // Shift by 2*pi toward the other sign; zero moves down
    function automatic longint flip_two_pi(input longint x);
        return (x < 0) ? x + TWO_PI_I : x - TWO_PI_I;
    endfunction

    function automatic logic [63:0] square_mag(input longint d);
        logic [63:0] m;
        m = (d < 0) ? -d : d;
        return m * m;
    endfunction

    // Exact squared distance, wide enough for three full squares
    function automatic logic [65:0] squared_distance(input longint dx, input longint dy,
                                                     input longint dz);
        return {2'b00, square_mag(dx)} + {2'b00, square_mag(dy)}
             + {2'b00, square_mag(dz)};
    endfunction

    // Pick the closest of the four equivalent orientations, earliest on a tie
    function automatic orient_rsp_t nearest_orientation(input orient_cmd_t c);
        longint      cur[3];
        longint      tgt[3];
        longint      red[3];
        longint      cand[3];
        longint      best[3];
        longint      delta;
        logic [65:0] best_d;
        logic [65:0] d;
        orient_rsp_t r;
        r.offset_rx = '0;
        r.offset_ry = '0;
        r.offset_rz = '0;
        r.applied   = 1'b0;
        if (c.group_id != ACTIVE_GROUP || c.axis_count != AXES_REQUIRED)
            return r;
        cur[0] = c.cur_rx;
        cur[1] = c.cur_ry;
        cur[2] = c.cur_rz;
        tgt[0] = c.tgt_rx;
        tgt[1] = c.tgt_ry;
        tgt[2] = c.tgt_rz;
        for (int i = 0; i < 3; i++)
        begin
            red[i]  = wrap_two_pi(cur[i]);
            best[i] = cur[i];
        end
        best_d = squared_distance(tgt[0] - cur[0], tgt[1] - cur[1], tgt[2] - cur[2]);
        // rx shifted, rz shifted, both shifted
        for (int k = 0; k < 3; k++)
        begin
            cand[0] = (k != 1) ? flip_two_pi(red[0]) : red[0];
            cand[1] = red[1];
            cand[2] = (k != 0) ? flip_two_pi(red[2]) : red[2];
            d = squared_distance(tgt[0] - cand[0], tgt[1] - cand[1], tgt[2] - cand[2]);
            if (d < best_d)
            begin
                best_d = d;
                for (int i = 0; i < 3; i++)
                    best[i] = cand[i];
            end
        end
        delta = best[0] - cur[0];
        r.offset_rx = delta[32:0];
        delta = best[1] - cur[1];
        r.offset_ry = delta[32:0];
        delta = best[2] - cur[2];
        r.offset_rz = delta[32:0];
        r.applied = 1'b1;
        return r;
    endfunction

    // Mostly back to back, some short pauses, a few long ones
    function automatic int draw_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Full range, inside one turn, near whole turns, or near the rails
    function automatic logic signed [31:0] pick_angle();
        longint v;
        case ($urandom_range(0, 3))
            0: v = longint'($signed($urandom));
            1: v = longint'($urandom_range(0, 2 * TWO_PI_I)) - TWO_PI_I;
            2: v = (longint'($urandom_range(0, 4)) - 2) * TWO_PI_I
                   + longint'($urandom_range(0, 16)) - 8;
            default:
                v = $urandom_range(0, 1) ? 64'sd2147483647 - $urandom_range(0, 1000)
                                         : -64'sd2147483648 + $urandom_range(0, 1000);
        endcase
        return v[31:0];
    endfunction

    // Target about a whole number of turns away, so shifted candidates compete
    function automatic logic signed [31:0] near_angle(input logic signed [31:0] base);
        longint v;
        v = longint'(base) + (longint'($urandom_range(0, 4)) - 2) * TWO_PI_I
            + longint'($urandom_range(0, 1 << 25)) - (1 << 24);
        return v[31:0];
    endfunction

    task automatic queue_cmd(input logic signed [31:0] cr, input logic signed [31:0] cy,
                             input logic signed [31:0] cz, input logic signed [31:0] tr,
                             input logic signed [31:0] ty, input logic signed [31:0] tz,
                             input logic [3:0] grp, input logic [3:0] axes, input int gap);
        orient_cmd_t c;
        c.cur_rx     = cr;
        c.cur_ry     = cy;
        c.cur_rz     = cz;
        c.tgt_rx     = tr;
        c.tgt_ry     = ty;
        c.tgt_rz     = tz;
        c.group_id   = grp;
        c.axis_count = axes;
        c.gap        = gap;
        pending_cmds.push_back(c);
    endtask

    // Drive commands; predict each one as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_if.valid      <= 1'b0;
            cmd_if.cur_rx     <= '0;
            cmd_if.cur_ry     <= '0;
            cmd_if.cur_rz     <= '0;
            cmd_if.tgt_rx     <= '0;
            cmd_if.tgt_ry     <= '0;
            cmd_if.tgt_rz     <= '0;
            cmd_if.group_id   <= '0;
            cmd_if.axis_count <= '0;
            cmd_hold <= 0;
        end
        else
        begin
            if (cmd_if.valid && cmd_if.ready)
                expected_offsets.push_back(nearest_orientation(cmd_now));
            if (!cmd_if.valid || cmd_if.ready)
            begin
                if (cmd_hold > 0)
                begin
                    cmd_if.valid <= 1'b0;
                    cmd_hold <= cmd_hold - 1;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cmd_now = pending_cmds.pop_front();
                    cmd_if.cur_rx     <= cmd_now.cur_rx;
                    cmd_if.cur_ry     <= cmd_now.cur_ry;
                    cmd_if.cur_rz     <= cmd_now.cur_rz;
                    cmd_if.tgt_rx     <= cmd_now.tgt_rx;
                    cmd_if.tgt_ry     <= cmd_now.tgt_ry;
                    cmd_if.tgt_rz     <= cmd_now.tgt_rz;
                    cmd_if.group_id   <= cmd_now.group_id;
                    cmd_if.axis_count <= cmd_now.axis_count;
                    cmd_if.valid      <= 1'b1;
                    cmd_hold <= cmd_now.gap;
                end
                else
                begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // Check each response against the oldest prediction; stall the response side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            rsp_hold <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_offsets.size() == 0)
                begin
                    $display("%0t: unexpected response, offsets %0d %0d %0d applied %0b",
                             $time, rsp_if.offset_rx, rsp_if.offset_ry, rsp_if.offset_rz,
                             rsp_if.applied);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_offsets.pop_front();
                    if (rsp_if.offset_rx !== want.offset_rx)
                    begin
                        $display("%0t: offset_rx expected %0d, got %0d",
                                 $time, want.offset_rx, rsp_if.offset_rx);
                        mismatch_count++;
                    end
                    if (rsp_if.offset_ry !== want.offset_ry)
                    begin
                        $display("%0t: offset_ry expected %0d, got %0d",
                                 $time, want.offset_ry, rsp_if.offset_ry);
                        mismatch_count++;
                    end
                    if (rsp_if.offset_rz !== want.offset_rz)
                    begin
                        $display("%0t: offset_rz expected %0d, got %0d",
                                 $time, want.offset_rz, rsp_if.offset_rz);
                        mismatch_count++;
                    end
                    if (rsp_if.applied !== want.applied)
                    begin
                        $display("%0t: applied expected %0b, got %0b",
                                 $time, want.applied, rsp_if.applied);
                        mismatch_count++;
                    end
                end
            end
            // hold off, or stay open through a quiet stretch
            if (rsp_hold > 0)
            begin
                rsp_if.ready <= 1'b0;
                rsp_hold <= rsp_hold - 1;
            end
            else if (((results_seen / 50) % 4) == 1 || $urandom_range(0, 3) != 0)
            begin
                rsp_if.ready <= 1'b1;
            end
            else
            begin
                rsp_if.ready <= 1'b0;
                rsp_hold <= draw_idle();
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        logic signed [31:0] cr, cy, cz, tr, ty, tz;
        logic        [3:0]  grp, axes;
        bit                 calm;

        // zero distance: the unchanged orientation wins
        queue_cmd(0, 0, 0, 0, 0, 0, ACTIVE_GROUP, AXES_REQUIRED, 0);
        // rails
        queue_cmd(ANG_MAX, ANG_MAX, ANG_MAX, ANG_MIN, ANG_MIN, ANG_MIN,
                  ACTIVE_GROUP, AXES_REQUIRED, 0);
        queue_cmd(ANG_MIN, ANG_MIN, ANG_MIN, ANG_MAX, ANG_MAX, ANG_MAX,
                  ACTIVE_GROUP, AXES_REQUIRED, 1);
        queue_cmd(ANG_MAX, ANG_MAX, ANG_MAX, ANG_MAX, ANG_MAX, ANG_MAX,
                  ACTIVE_GROUP, AXES_REQUIRED, 0);
        queue_cmd(ANG_MIN, ANG_MIN, ANG_MIN, ANG_MIN, ANG_MIN, ANG_MIN,
                  ACTIVE_GROUP, AXES_REQUIRED, 0);
        queue_cmd(ANG_MAX, 0, ANG_MIN, ANG_MIN, 0, ANG_MAX, ACTIVE_GROUP, AXES_REQUIRED, 0);
        // exact turns and just inside them
        queue_cmd(TWO_PI_I, TWO_PI_I, TWO_PI_I, 0, 0, 0, ACTIVE_GROUP, AXES_REQUIRED, 2);
        queue_cmd(-TWO_PI_I, -TWO_PI_I, -TWO_PI_I, 0, 0, 0, ACTIVE_GROUP, AXES_REQUIRED, 0);
        queue_cmd(TWO_PI_I - 1, -(TWO_PI_I - 1), 2 * TWO_PI_I, 0, 0, 0,
                  ACTIVE_GROUP, AXES_REQUIRED, 0);
        queue_cmd(2 * TWO_PI_I, -2 * TWO_PI_I, 2 * TWO_PI_I - 1, -PI_I, PI_I, -PI_I,
                  ACTIVE_GROUP, AXES_REQUIRED, 0);
        queue_cmd(-2 * TWO_PI_I + 1, 2 * TWO_PI_I + 5, -2 * TWO_PI_I - 5, PI_I, 0, PI_I,
                  ACTIVE_GROUP, AXES_REQUIRED, 0);
        // near four-way tie won by the unchanged orientation, then each shifted candidate winning in turn
        queue_cmd(0, 0, 0, -PI_I, 0, -PI_I, ACTIVE_GROUP, AXES_REQUIRED, 0);
        queue_cmd(0, 0, 0, -PI_I - 1000, 0, -PI_I + 1000, ACTIVE_GROUP, AXES_REQUIRED, 0);
        queue_cmd(0, 0, 0, -PI_I + 1000, 0, -PI_I - 1000, ACTIVE_GROUP, AXES_REQUIRED, 0);
        queue_cmd(0, 0, 0, -500000000, 0, -500000000, ACTIVE_GROUP, AXES_REQUIRED, 0);
        // x-shifted and z-shifted candidates tie each other; the both-shifted one is closer
        queue_cmd(PI_I, 0, PI_I, -PI_I - 10, 0, -PI_I - 10, ACTIVE_GROUP, AXES_REQUIRED, 0);
        queue_cmd(1, 7, -1, -TWO_PI_I, 3, TWO_PI_I, ACTIVE_GROUP, AXES_REQUIRED, 3);
        // commands that are not processed
        queue_cmd(PI_I, PI_I, PI_I, 0, 0, 0, 4'd1, AXES_REQUIRED, 0);
        queue_cmd(PI_I, PI_I, PI_I, 0, 0, 0, 4'd15, AXES_REQUIRED, 0);
        queue_cmd(ANG_MAX, ANG_MIN, PI_I, 0, 0, 0, ACTIVE_GROUP, 4'd5, 0);
        queue_cmd(ANG_MIN, ANG_MAX, PI_I, 0, 0, 0, ACTIVE_GROUP, 4'd15, 0);
        queue_cmd(-PI_I, PI_I, -PI_I, 1, 1, 1, ACTIVE_GROUP, 4'd0, 0);
        queue_cmd(-PI_I, PI_I, -PI_I, 1, 1, 1, 4'd8, 4'd7, 0);

        // random commands, mostly processed, with stretches sent back to back
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            calm = ((n / 60) % 4) == 2;
            if ($urandom_range(0, 99) < 15)
            begin
                grp  = $urandom;
                axes = $urandom;
            end
            else
            begin
                grp  = ACTIVE_GROUP;
                axes = AXES_REQUIRED;
            end
            cr = pick_angle();
            cy = pick_angle();
            cz = pick_angle();
            tr = $urandom_range(0, 1) ? pick_angle() : near_angle(cr);
            ty = $urandom_range(0, 1) ? pick_angle() : near_angle(cy);
            tz = $urandom_range(0, 1) ? pick_angle() : near_angle(cz);
            queue_cmd(cr, cy, cz, tr, ty, tz, grp, axes, calm ? 0 : draw_idle());
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain, then allow for the pipeline depth
        while (pending_cmds.size() != 0 || cmd_if.valid || expected_offsets.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0 && expected_offsets.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
